[hdl/dhkit_pkg.sv]
// ----------------------------------------------------------------------------
// dhkit_pkg
// Shared types, constants and hash functions of the double-hash key index table.
// ----------------------------------------------------------------------------
package dhkit_pkg;

  localparam int TABLE_BITS = 12;
  localparam int SLOT_MAX   = 1 << TABLE_BITS;
  localparam int HALF_BITS  = TABLE_BITS - 1;
  localparam int HALF_MAX   = 1 << HALF_BITS;

  typedef logic [TABLE_BITS-1:0] slot_t;
  typedef logic [TABLE_BITS:0]   slot_cnt_t;
  typedef logic [HALF_BITS:0]    cnt_t;

  localparam logic [2:0] ACT_FIND   = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_ISTART = 3'd3;
  localparam logic [2:0] ACT_INEXT  = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [3:0] ST_FOUND    = 4'd0;
  localparam logic [3:0] ST_INSERTED = 4'd1;
  localparam logic [3:0] ST_PRESENT  = 4'd2;
  localparam logic [3:0] ST_NOTFOUND = 4'd3;
  localparam logic [3:0] ST_REMOVED  = 4'd4;
  localparam logic [3:0] ST_FULL     = 4'd5;
  localparam logic [3:0] ST_ENTRY    = 4'd6;
  localparam logic [3:0] ST_DONE     = 4'd7;
  localparam logic [3:0] ST_OK       = 4'd8;
  localparam logic [3:0] ST_BADKEY   = 4'd9;

  localparam logic [63:0] KEY_EMPTY = 64'd0;
  localparam logic [63:0] KEY_TOMB  = 64'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] key;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [10:0] index;
    logic [63:0] key_out;
    logic [11:0] live_count;
  } out_item_t;

  // Write port of the slot memory.
  typedef struct packed {
    logic        we;
    slot_t       addr;
    logic [63:0] key;
    logic        idx_we;
    cnt_t        idx;
  } slot_wr_t;

  function automatic logic [63:0] home_hash(input logic [63:0] k);
    logic [63:0] h;
    h = '0;
    for (int i = 0; i <= 12; i++) h ^= 64'($signed(k) >>> (5 * i));
    return h;
  endfunction

  function automatic logic [63:0] step_hash(input logic [63:0] k);
    logic [63:0] d;
    d = '0;
    for (int i = 0; i <= 9; i++) d ^= 64'($signed(k) >>> (7 * i));
    return d;
  endfunction

endpackage

[hdl/dhkit_slot_mem.sv]
// ----------------------------------------------------------------------------
// dhkit_slot_mem
// Key and index memories of the table, one read and one write port each,
// registered read data. Keys carry a clear epoch so a table clear is instant.
// ----------------------------------------------------------------------------
module dhkit_slot_mem (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clr,
  input  dhkit_pkg::slot_t        rd_addr,
  input  dhkit_pkg::slot_wr_t     wr,
  output logic [63:0]             rd_key,
  output dhkit_pkg::cnt_t         rd_idx,
  output logic                    rdy
);
  import dhkit_pkg::*;

  logic [63:0] key_mem [SLOT_MAX];
  cnt_t        idx_mem [SLOT_MAX];
  logic [7:0]  epoch_mem [SLOT_MAX];
  logic [7:0]  epoch_r;
  logic [63:0] key_q;
  logic [7:0]  ep_q;
  logic        rdy_r;
  slot_t       sweep_r;

  // Epoch marks wrap, so sweep every mark back to zero after reset and on
  // each wrap of the epoch counter; the sweep runs one slot a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= 8'd1;
      rdy_r   <= 1'b0;
      sweep_r <= '0;
    end else if (clr && epoch_r == 8'hFF) begin
      epoch_r <= 8'd1;
      rdy_r   <= 1'b0;
      sweep_r <= '0;
    end else begin
      if (!rdy_r) begin
        sweep_r <= sweep_r + 1'b1;
        if (sweep_r == slot_t'(SLOT_MAX - 1)) rdy_r <= 1'b1;
      end
      if (clr) epoch_r <= epoch_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rdy_r) begin
      epoch_mem[sweep_r] <= 8'd0;
    end else if (wr.we) begin
      epoch_mem[wr.addr] <= epoch_r;
    end
    if (wr.we) key_mem[wr.addr] <= wr.key;
    if (wr.idx_we) idx_mem[wr.addr] <= wr.idx;
    key_q  <= key_mem[rd_addr];
    ep_q   <= epoch_mem[rd_addr];
    rd_idx <= idx_mem[rd_addr];
  end

  assign rd_key = (ep_q == epoch_r) ? key_q : KEY_EMPTY;
  assign rdy    = rdy_r;
endmodule

[hdl/dhkit_free_stack.sv]
// ----------------------------------------------------------------------------
// dhkit_free_stack
// LIFO of freed indices, synchronous memory with registered read of the top.
// ----------------------------------------------------------------------------
module dhkit_free_stack (
  input  logic              clk,
  input  logic              push,
  input  dhkit_pkg::cnt_t   push_addr,
  input  dhkit_pkg::cnt_t   push_val,
  input  dhkit_pkg::cnt_t   rd_addr,
  output dhkit_pkg::cnt_t   rd_val
);
  import dhkit_pkg::*;

  cnt_t mem [HALF_MAX];

  always_ff @(posedge clk) begin
    if (push) mem[push_addr[HALF_BITS-1:0]] <= push_val;
    rd_val <= mem[rd_addr[HALF_BITS-1:0]];
  end
endmodule

[hdl/double_hash_key_index_table_unit.sv]
// ----------------------------------------------------------------------------
// double_hash_key_index_table_unit
// Open-addressed key to dense index table with double hashing.
//
// in_valid/in_ready carry one transaction {action, key}; out_valid/out_ready
// return exactly one result per transaction. Items are handled one at a time.
// Find, add and remove probe the key memory once per slot visited, each probe
// passing through the registered memory read in S_READ and S_EVAL; an add that
// inserts goes through a further S_POP state. Iterator next scans slots the same way.
// Clear, iterator start, an iterator next past the end and a refused
// transaction go from S_START straight to S_DONE. Probes are serialised by
// the single read port of the slot memory.
// After reset, and again on every 255th table clear, the slot memory runs a
// clearing pass over all 4096 slots during which no transaction is taken.
// The result sits in an output register; while out_ready is low the next
// transaction is still accepted but not started until the result leaves.
// cfg_we writes size_bits and clears the table.
// ----------------------------------------------------------------------------
module double_hash_key_index_table_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dhkit_pkg::in_item_t    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dhkit_pkg::out_item_t   out_data
);
  import dhkit_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_START, S_READ, S_EVAL, S_POP, S_DONE} state_t;

  state_t      state_r;
  in_item_t    item_r;
  logic        have_r;
  logic [3:0]  bits_r;
  slot_t       mask_r;
  slot_t       pos_r, step_r;
  slot_cnt_t   n_r;
  logic        tomb_ok_r;
  slot_t       tomb_r;
  slot_cnt_t   iter_r;
  logic        iter_neg_r;
  cnt_t        free_r, issued_r, budget_r;
  out_item_t   res_r;
  logic        clr_req;
  slot_t       tgt_r;
  logic        fresh_r;

  logic [63:0] rd_key;
  cnt_t        rd_idx, stk_val;
  slot_wr_t    wr;
  logic        push;
  slot_t       rd_addr;
  logic        mem_ready;

  out_item_t   st_res;
  state_t      st_next;
  slot_t       st_pos;
  slot_cnt_t   st_iter;
  slot_cnt_t   inext_p;

  logic [3:0] eff_bits;
  always_comb begin
    eff_bits = bits_r;
    if (bits_r < 4'd7) eff_bits = 4'd7;
    if (bits_r > 4'(TABLE_BITS)) eff_bits = 4'(TABLE_BITS);
  end
  slot_t     mask_c;
  slot_cnt_t size_c;
  assign mask_c = slot_t'((1 << eff_bits) - 1);
  assign size_c = slot_cnt_t'(1 << eff_bits);

  assign clr_req = cfg_we || (state_r == S_START && item_r.action == ACT_CLEAR);

  assign rd_addr = pos_r;

  dhkit_slot_mem u_mem (
    .clk(clk), .rst_n(rst_n), .clr(clr_req), .rd_addr(rd_addr), .wr(wr),
    .rd_key(rd_key), .rd_idx(rd_idx), .rdy(mem_ready)
  );

  dhkit_free_stack u_stk (
    .clk(clk), .push(push), .push_addr(free_r), .push_val(rd_idx),
    .rd_addr(free_r - 1'b1), .rd_val(stk_val)
  );

  assign in_ready = !have_r && mem_ready;
  logic [11:0] live_c;
  assign live_c = 12'(issued_r - free_r);

  // Decode of a new transaction in S_START.
  always_comb begin
    inext_p = iter_neg_r ? '0 : iter_r + 1'b1;
    st_res = '0;
    st_res.status = ST_OK;
    st_next = S_DONE;
    st_pos = slot_t'(home_hash(item_r.key)) & mask_c;
    st_iter = iter_r;
    if (item_r.action <= ACT_REMOVE &&
        (item_r.key == KEY_EMPTY || item_r.key == KEY_TOMB)) begin
      st_res.status = ST_BADKEY;
    end else begin
      case (item_r.action) inside
        ACT_FIND, ACT_REMOVE: st_next = S_READ;
        ACT_ADD: begin
          if (budget_r == '0) st_res.status = ST_FULL;
          else st_next = S_READ;
        end
        ACT_INEXT: begin
          if (inext_p >= size_c) begin
            st_iter = size_c;
            st_res.status = ST_DONE;
          end else begin
            st_iter = inext_p;
            st_pos = inext_p[TABLE_BITS-1:0];
            st_next = S_READ;
          end
        end
        ACT_ISTART, ACT_CLEAR: ;
        default: st_res.status = ST_BADKEY;
      endcase
    end
  end

  // Evaluation of the probe in S_EVAL.
  logic hit, empty, tomb, last;
  assign hit   = rd_key == item_r.key;
  assign empty = rd_key == KEY_EMPTY;
  assign tomb  = rd_key == KEY_TOMB;
  assign last  = (n_r + 1'b1) == size_c;

  always_comb begin
    wr = '0;
    push = 1'b0;
    if (state_r == S_EVAL) begin
      if (item_r.action == ACT_REMOVE && hit) begin
        wr.we = 1'b1; wr.addr = pos_r; wr.key = KEY_TOMB;
        push = free_r < cnt_t'(HALF_MAX);
      end
    end else if (state_r == S_POP) begin
      wr.we = 1'b1; wr.addr = tgt_r; wr.key = item_r.key; wr.idx_we = 1'b1;
      wr.idx = fresh_r ? issued_r + 1'b1 : stk_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      have_r     <= 1'b0;
      out_valid  <= 1'b0;
      bits_r     <= 4'd12;
      free_r     <= '0;
      issued_r   <= '0;
      budget_r   <= cnt_t'(HALF_MAX);
      iter_r     <= '0;
      iter_neg_r <= 1'b1;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) begin
        item_r <= in_data;
        have_r <= 1'b1;
      end
      if (cfg_we) bits_r <= cfg_wdata;
      if (clr_req) begin
        free_r   <= '0;
        issued_r <= '0;
        budget_r <= cfg_we ? cnt_t'(1 << (((cfg_wdata < 4'd7) ? 4'd7 :
                      (cfg_wdata > 4'(TABLE_BITS)) ? 4'(TABLE_BITS) : cfg_wdata) - 1))
                    : cnt_t'(size_c >> 1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (have_r && !out_valid) state_r <= S_START;
        end
        S_START: begin
          res_r     <= st_res;
          mask_r    <= mask_c;
          n_r       <= '0;
          tomb_ok_r <= 1'b0;
          pos_r     <= st_pos;
          step_r    <= (slot_t'(step_hash(item_r.key)) & mask_c) | slot_t'(1);
          state_r   <= st_next;
          if (item_r.action == ACT_ISTART) begin
            iter_neg_r <= 1'b1;
          end else if (item_r.action == ACT_INEXT) begin
            iter_neg_r <= 1'b0;
            iter_r     <= st_iter;
          end
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: begin
          if (item_r.action == ACT_INEXT) begin
            if (!empty && !tomb) begin
              res_r.status  <= ST_ENTRY;
              res_r.key_out <= rd_key;
              res_r.index   <= 11'(rd_idx - 1'b1);
              state_r <= S_DONE;
            end else if (iter_r + 1'b1 >= size_c) begin
              iter_r <= size_c;
              res_r.status <= ST_DONE;
              state_r <= S_DONE;
            end else begin
              iter_r  <= iter_r + 1'b1;
              pos_r   <= pos_r + 1'b1;
              state_r <= S_READ;
            end
          end else if (hit) begin
            state_r <= S_DONE;
            case (item_r.action)
              ACT_FIND: begin
                res_r.status <= ST_FOUND;
                res_r.index  <= 11'(rd_idx - 1'b1);
              end
              ACT_ADD: begin
                res_r.status <= ST_PRESENT;
                res_r.index  <= 11'(rd_idx - 1'b1);
              end
              default: begin
                res_r.status <= ST_REMOVED;
                if (free_r < cnt_t'(HALF_MAX)) free_r <= free_r + 1'b1;
              end
            endcase
          end else if (empty || last) begin
            if (item_r.action == ACT_ADD && (empty || tomb_ok_r || tomb)) begin
              tgt_r   <= tomb_ok_r ? tomb_r : pos_r;
              if (!tomb_ok_r && !tomb) budget_r <= budget_r - 1'b1;
              fresh_r <= !(free_r > '0 && free_r <= cnt_t'(HALF_MAX));
              state_r <= S_POP;
            end else if (item_r.action == ACT_ADD) begin
              res_r.status <= ST_FULL;
              state_r <= S_DONE;
            end else begin
              res_r.status <= ST_NOTFOUND;
              state_r <= S_DONE;
            end
          end else begin
            if (tomb && !tomb_ok_r) begin
              tomb_ok_r <= 1'b1;
              tomb_r    <= pos_r;
            end
            n_r     <= n_r + 1'b1;
            pos_r   <= (pos_r + step_r) & mask_r;
            state_r <= S_READ;
          end
        end
        S_POP: begin
          res_r.status <= ST_INSERTED;
          if (fresh_r) begin
            issued_r <= issued_r + 1'b1;
            res_r.index <= 11'(issued_r);
          end else begin
            free_r <= free_r - 1'b1;
            res_r.index <= 11'(stk_val - 1'b1);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_data  <= '{status: res_r.status, index: res_r.index,
                         key_out: res_r.key_out, live_count: live_c};
          out_valid <= 1'b1;
          have_r    <= 1'b0;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
